FILE: rtl/lup_pkg.sv
// ----------------------------------------------------------------------------
// lup_pkg
// Shared constants, types and helpers of the 4x4 LUP solver.
// ----------------------------------------------------------------------------
package lup_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(DIM);
  localparam int ADDR_W    = $clog2(DIM * DIM);
  localparam int FLOOR_W   = 31;

  localparam int IN_BITS     = 2 * IDX_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * IDX_W + DATA_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int DIV_STEPS = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int APB_ADDR_W = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  typedef enum logic [1:0] {
    ACT_WR_MAT = 2'd0,
    ACT_FACTOR = 2'd1,
    ACT_WR_RHS = 2'd2,
    ACT_SOLVE  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_SRD, ST_F_SCMP,
    ST_F_XA, ST_F_XB, ST_F_XC, ST_F_XD,
    ST_F_PRD, ST_F_PCHK,
    ST_F_NRD, ST_F_NDIV, ST_F_NWAIT,
    ST_F_ERD1, ST_F_ERD2, ST_F_EMUL, ST_F_ESUB,
    ST_S_INIT, ST_S_SWP,
    ST_S_LRD, ST_S_LMUL, ST_S_LSUB,
    ST_S_DRD, ST_S_DDIV, ST_S_DWAIT,
    ST_S_BRD, ST_S_BMUL, ST_S_BSUB,
    ST_EMIT
  } state_e;

  typedef logic [DATA_W-1:0] word_t;

  function automatic word_t mag(input word_t v);
    mag = v[DATA_W-1] ? (~v + word_t'(1)) : v;
  endfunction

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    mat_addr = ADDR_W'(int'(r) * DIM + int'(c));
  endfunction

endpackage

FILE: rtl/lup_solver_4x4.sv
// ----------------------------------------------------------------------------
// lup_solver_4x4
// 4x4 Q16.16 linear solver: load, Crout LUP factor with pivoting, solve.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one request: tuser = action (write matrix entry,
//   factor, write rhs entry, solve); tdata = row, col, value.
//   Writes are stored on acceptance and return nothing. Factor returns four
//   results carrying the pivot row of each column; solve returns x0..x3.
//   The output stream packs index, value_out, pivot_row; tlast marks the
//   fourth result.
//   One shared 32x32 multiplier (registered) and one bit-serial divider do
//   all multiplies and divides under a sequencer; matrix entries sit in a
//   16-entry RAM with one read port, so entries are read one at a time.
//   Factor works column by column: a row swap where needed, then
//   normalization and elimination unless the column is skipped. Four
//   results follow a factor or solve; tready is low from the accepted
//   request until the last result is taken.
//   If the receiver stalls, the current result holds and the sequencer waits.
//   Reset returns the sequencer to idle, pivot order to identity, the
//   solution to zero and pivot_floor to zero. The APB port holds pivot_floor
//   at address 0; write it only while idle.
// ----------------------------------------------------------------------------
module lup_solver_4x4
  import lup_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // tuser: action[1:0]
  input  logic [1:0]              s_axis_tuser,
  // tdata: row[1:0], col[3:2], value[35:4], zero pad
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: index[1:0], value_out[33:2], pivot_row[35:34], zero pad
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                    m_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  state_e state_q, state_d;

  logic [FLOOR_W-1:0] floor_q;
  logic [IDX_W-1:0]   k_q, i_q, j_q, p_q, e_q;
  logic [IDX_W-1:0]   piv_q [DIM];
  word_t              x_q [DIM];
  word_t              b_q [DIM];
  word_t              rhs_q [DIM];
  word_t              best_q, pv_q, t_q, l_q, acc_q;
  logic               mode_solve_q;
  logic signed [2*DATA_W-1:0] prod_q;
  word_t              mq;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  word_t              ram_wdata, rd;

  logic               div_start, div_done;
  word_t              div_num, div_quo;
  word_t              mul_a;

  logic               in_acc, out_acc;
  logic [IDX_W-1:0]   in_row, in_col;
  word_t              in_val;
  word_t              rd_mag;
  logic               srch_take;
  logic [IDX_W-1:0]   p_new;

  assign in_row = s_axis_tdata[IDX_W-1:0];
  assign in_col = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_val = s_axis_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  assign mq        = prod_q[FRAC_BITS+DATA_W-1:FRAC_BITS];
  assign rd_mag    = mag(rd);
  assign srch_take = (j_q == k_q) || (best_q < rd_mag);
  assign p_new     = srch_take ? j_q : p_q;
  assign mul_a     = (state_q == ST_F_EMUL) ? l_q : x_q[i_q];
  assign div_num   = (state_q == ST_F_NDIV) ? rd : acc_q;

  // APB: pivot_floor at register 0
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == 1'b0) ? {1'b0, floor_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[APB_ADDR_W-1]) begin
      floor_q <= pwdata[FLOOR_W-1:0];
    end
  end

  lup_ram #(.WIDTH(DATA_W), .DEPTH(DIM * DIM)) u_mat (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  lup_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ((state_q == ST_F_NDIV) ? pv_q : rd),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(mul_a) * $signed(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, RAM port and divider start
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = mat_addr(in_row, in_col);
    ram_wdata = in_val;
    ram_raddr = mat_addr(j_q, k_q);
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_e'(s_axis_tuser))
            ACT_WR_MAT: ram_we  = 1'b1;
            ACT_FACTOR: state_d = ST_F_SRD;
            ACT_SOLVE:  state_d = ST_S_INIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_F_SRD: state_d = ST_F_SCMP;
      ST_F_SCMP: begin
        if (j_q == LAST_IDX) begin
          state_d = (p_new != k_q) ? ST_F_XA : ST_F_PRD;
        end else begin
          state_d = ST_F_SRD;
        end
      end
      ST_F_XA: begin
        ram_raddr = mat_addr(k_q, j_q);
        state_d   = ST_F_XB;
      end
      ST_F_XB: begin
        ram_raddr = mat_addr(p_q, j_q);
        state_d   = ST_F_XC;
      end
      ST_F_XC: begin
        ram_we    = 1'b1;
        ram_waddr = mat_addr(k_q, j_q);
        ram_wdata = rd;
        state_d   = ST_F_XD;
      end
      ST_F_XD: begin
        ram_we    = 1'b1;
        ram_waddr = mat_addr(p_q, j_q);
        ram_wdata = t_q;
        state_d   = (j_q == LAST_IDX) ? ST_F_PRD : ST_F_XA;
      end
      ST_F_PRD: begin
        ram_raddr = mat_addr(k_q, k_q);
        state_d   = ST_F_PCHK;
      end
      ST_F_PCHK: begin
        if (rd_mag < {1'b0, floor_q} || k_q == LAST_IDX) begin
          state_d = (k_q == LAST_IDX) ? ST_EMIT : ST_F_SRD;
        end else begin
          state_d = ST_F_NRD;
        end
      end
      ST_F_NRD: begin
        ram_raddr = mat_addr(k_q, j_q);
        state_d   = ST_F_NDIV;
      end
      ST_F_NDIV: begin
        div_start = 1'b1;
        state_d   = ST_F_NWAIT;
      end
      ST_F_NWAIT: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_waddr = mat_addr(k_q, j_q);
          ram_wdata = div_quo;
          state_d   = (j_q == LAST_IDX) ? ST_F_ERD1 : ST_F_NRD;
        end
      end
      ST_F_ERD1: begin
        ram_raddr = mat_addr(i_q, k_q);
        state_d   = ST_F_ERD2;
      end
      ST_F_ERD2: begin
        ram_raddr = mat_addr(k_q, j_q);
        state_d   = ST_F_EMUL;
      end
      ST_F_EMUL: begin
        ram_raddr = mat_addr(i_q, j_q);
        state_d   = ST_F_ESUB;
      end
      ST_F_ESUB: begin
        ram_we    = 1'b1;
        ram_waddr = mat_addr(i_q, j_q);
        ram_wdata = rd - mq;
        if (j_q == LAST_IDX && i_q == LAST_IDX) begin
          state_d = ST_F_SRD;
        end else begin
          state_d = ST_F_ERD1;
        end
      end
      ST_S_INIT: state_d = ST_S_SWP;
      ST_S_SWP:  state_d = (k_q == '0) ? ST_S_DRD : ST_S_LRD;
      ST_S_LRD: begin
        ram_raddr = mat_addr(k_q, i_q);
        state_d   = ST_S_LMUL;
      end
      ST_S_LMUL: state_d = ST_S_LSUB;
      ST_S_LSUB: state_d = (i_q == k_q - IDX_W'(1)) ? ST_S_DRD : ST_S_LRD;
      ST_S_DRD: begin
        ram_raddr = mat_addr(k_q, k_q);
        state_d   = ST_S_DDIV;
      end
      ST_S_DDIV: begin
        div_start = 1'b1;
        state_d   = ST_S_DWAIT;
      end
      ST_S_DWAIT: begin
        if (div_done) begin
          state_d = (k_q == LAST_IDX) ? ST_S_BRD : ST_S_SWP;
        end
      end
      ST_S_BRD: begin
        ram_raddr = mat_addr(k_q, i_q);
        state_d   = ST_S_BMUL;
      end
      ST_S_BMUL: state_d = ST_S_BSUB;
      ST_S_BSUB: begin
        if (i_q == LAST_IDX && k_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_S_BRD;
        end
      end
      ST_EMIT: begin
        if (out_acc && e_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers of the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      p_q          <= '0;
      e_q          <= '0;
      mode_solve_q <= 1'b0;
      for (int n = 0; n < DIM; n++) begin
        piv_q[n] <= IDX_W'(n);
        x_q[n]   <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          j_q <= '0;
          e_q <= '0;
          if (in_acc) begin
            mode_solve_q <= (action_e'(s_axis_tuser) == ACT_SOLVE);
          end
        end
        ST_F_SCMP: begin
          p_q <= p_new;
          if (j_q == LAST_IDX) begin
            piv_q[k_q] <= p_new;
            j_q        <= '0;
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_F_XD: j_q <= j_q + IDX_W'(1);
        ST_F_PCHK: begin
          // skip the column when the pivot is below pivot_floor or it is the last column
          if (rd_mag < {1'b0, floor_q} || k_q == LAST_IDX) begin
            k_q <= k_q + IDX_W'(1);
            j_q <= k_q + IDX_W'(1);
          end else begin
            j_q <= k_q + IDX_W'(1);
          end
        end
        ST_F_NWAIT: begin
          if (div_done) begin
            if (j_q == LAST_IDX) begin
              i_q <= k_q + IDX_W'(1);
              j_q <= k_q + IDX_W'(1);
            end else begin
              j_q <= j_q + IDX_W'(1);
            end
          end
        end
        ST_F_ESUB: begin
          if (j_q == LAST_IDX) begin
            if (i_q == LAST_IDX) begin
              k_q <= k_q + IDX_W'(1);
              j_q <= k_q + IDX_W'(1);
            end else begin
              i_q <= i_q + IDX_W'(1);
              j_q <= k_q + IDX_W'(1);
            end
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_S_SWP: i_q <= '0;
        ST_S_LSUB: i_q <= i_q + IDX_W'(1);
        ST_S_DWAIT: begin
          if (div_done) begin
            x_q[k_q] <= div_quo;
            if (k_q == LAST_IDX) begin
              k_q <= IDX_W'(DIM - 2);
              i_q <= LAST_IDX;
            end else begin
              k_q <= k_q + IDX_W'(1);
            end
          end
        end
        ST_S_BSUB: begin
          x_q[k_q] <= x_q[k_q] - mq;
          if (i_q == LAST_IDX) begin
            k_q <= k_q - IDX_W'(1);
            i_q <= k_q;
          end else begin
            i_q <= i_q + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            e_q <= e_q + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && action_e'(s_axis_tuser) == ACT_WR_RHS) begin
          rhs_q[in_row] <= in_val;
        end
      end
      ST_F_SCMP: begin
        if (srch_take) begin
          best_q <= rd_mag;
        end
      end
      ST_F_XB:   t_q   <= rd;
      ST_F_PCHK: pv_q  <= rd;
      ST_F_ERD2: l_q   <= rd;
      ST_S_INIT: begin
        for (int n = 0; n < DIM; n++) begin
          b_q[n] <= rhs_q[n];
        end
      end
      ST_S_SWP: begin
        // apply the recorded row swap to the rhs copy
        if (piv_q[k_q] != k_q) begin
          b_q[k_q]        <= b_q[piv_q[k_q]];
          b_q[piv_q[k_q]] <= b_q[k_q];
        end
        acc_q <= b_q[piv_q[k_q]];
      end
      ST_S_LSUB: acc_q <= acc_q - mq;
      default: ;
    endcase
  end

  assign m_axis_tdata = OUT_TDATA_W'({(mode_solve_q ? IDX_W'(0) : piv_q[e_q]),
                                      (mode_solve_q ? x_q[e_q] : word_t'(0)),
                                      e_q});
  assign m_axis_tlast = (e_q == LAST_IDX);

  property p_ready_excl;
    @(posedge clk_i) disable iff (!rst_ni) !(s_axis_tready && m_axis_tvalid);
  endproperty
  a_ready_excl: assert property (p_ready_excl) else $error("input ready while emitting");

  property p_div_start;
    @(posedge clk_i) disable iff (!rst_ni)
      div_start |-> (state_q == ST_F_NDIV || state_q == ST_S_DDIV);
  endproperty
  a_div_start: assert property (p_div_start) else $error("divider started out of sequence");

  property p_factor_start;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_acc && s_axis_tuser == ACT_FACTOR) |=> (state_q == ST_F_SRD && k_q == '0);
  endproperty
  a_factor_start: assert property (p_factor_start) else $error("factor did not start");

  property p_idle_write;
    @(posedge clk_i) disable iff (!rst_ni)
      (ram_we && state_q == ST_IDLE) |-> in_acc;
  endproperty
  a_idle_write: assert property (p_idle_write) else $error("matrix written without request");

endmodule

FILE: rtl/lup_ram.sv
// ----------------------------------------------------------------------------
// lup_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lup_div.sv
// ----------------------------------------------------------------------------
// lup_div
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero, one quotient bit per cycle. A zero divisor yields zero.
// ----------------------------------------------------------------------------
module lup_div
  import lup_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  done_o,
  output word_t quo_o
);

  localparam int QW = DATA_W + FRAC_BITS;

  logic                 busy_q, done_q, neg_q, zero_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  word_t                rem_q, dv_q;
  logic [QW-1:0]        q_q;
  logic [DATA_W:0]      trial;
  logic                 ge;

  assign trial = {rem_q, q_q[QW-1]};
  assign ge    = trial >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= {mag(num_i), {FRAC_BITS{1'b0}}};
      dv_q   <= mag(den_i);
      neg_q  <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      zero_q <= (den_i == '0);
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? word_t'(trial - {1'b0, dv_q}) : trial[DATA_W-1:0];
      q_q   <= {q_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : (neg_q ? (~q_q[DATA_W-1:0] + word_t'(1))
                                       : q_q[DATA_W-1:0]);

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !start_i;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

endmodule
